[sv/pbsa_pkg.sv]
// Shared definitions for the packed byte SIMD ALU: lane geometry, operation codes
// and the restoring division step used by the divider pipeline.
// No dependencies.
`default_nettype none

package pbsa_pkg;

    localparam int LANES       = 8;
    localparam int LANE_W      = 8;
    localparam int WORD_W      = LANES * LANE_W;
    localparam int DIV_STEPS   = 2;                    // quotient bits per divider stage
    localparam int DIV_STAGES  = LANE_W / DIV_STEPS;
    localparam int PIPE_STAGES = DIV_STAGES + 2;       // operand stage + divider + output

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_MUL   = 4'd2,
        MODE_DIV   = 4'd3,
        MODE_MOD   = 4'd4,
        MODE_AND   = 4'd5,
        MODE_OR    = 4'd6,
        MODE_NOT   = 4'd7,
        MODE_XOR   = 4'd8,
        MODE_NAND  = 4'd9,
        MODE_NOR   = 4'd10,
        MODE_EQUAL = 4'd11
    } t_mode;

    // One restoring step: shift the next dividend bit into the partial remainder,
    // subtract the divisor when it fits and shift the quotient bit in.
    // Returns {remainder, dividend/quotient shift word}.
    function automatic logic [2*LANE_W-1:0] div_step(
        input logic [LANE_W-1:0] rem,
        input logic [LANE_W-1:0] dq,
        input logic [LANE_W-1:0] d
    );
        logic [LANE_W:0]   t;
        logic [LANE_W+1:0] diff;
        logic              q;
        logic [LANE_W-1:0] rem_n;
        t     = {rem, dq[LANE_W-1]};
        diff  = {1'b0, t} - {2'b00, d};
        q     = ~diff[LANE_W+1];
        rem_n = q ? diff[LANE_W-1:0] : t[LANE_W-1:0];
        return {rem_n, dq[LANE_W-2:0], q};
    endfunction

endpackage

`default_nettype wire

[sv/pbsa_divider.sv]
// Pipelined unsigned divider for all byte lanes: DIV_STEPS quotient bits per stage.
// Depends on pbsa_pkg for lane geometry and the division step.
`default_nettype none

module pbsa_divider (
    input  wire                              i_clk,
    input  wire  [pbsa_pkg::DIV_STAGES-1:0]  i_en,        // per-stage load enable
    input  wire  [pbsa_pkg::WORD_W-1:0]      i_dividend,  // lane magnitudes
    input  wire  [pbsa_pkg::WORD_W-1:0]      i_divisor,   // lane magnitudes
    output logic [pbsa_pkg::WORD_W-1:0]      o_quotient,
    output logic [pbsa_pkg::WORD_W-1:0]      o_remainder
);

    logic [pbsa_pkg::WORD_W-1:0] r_rem [pbsa_pkg::DIV_STAGES];
    logic [pbsa_pkg::WORD_W-1:0] r_dq  [pbsa_pkg::DIV_STAGES];
    logic [pbsa_pkg::WORD_W-1:0] r_d   [pbsa_pkg::DIV_STAGES];
    logic [pbsa_pkg::WORD_W-1:0] n_rem [pbsa_pkg::DIV_STAGES];
    logic [pbsa_pkg::WORD_W-1:0] n_dq  [pbsa_pkg::DIV_STAGES];

    genvar g;
    generate
        for (g = 0; g < pbsa_pkg::DIV_STAGES; g++) begin : g_stage
            logic [pbsa_pkg::WORD_W-1:0] w_rem_in;
            logic [pbsa_pkg::WORD_W-1:0] w_dq_in;
            logic [pbsa_pkg::WORD_W-1:0] w_d_in;

            if (g == 0) begin : g_first
                assign w_rem_in = '0;
                assign w_dq_in  = i_dividend;
                assign w_d_in   = i_divisor;
            end else begin : g_next
                assign w_rem_in = r_rem[g-1];
                assign w_dq_in  = r_dq[g-1];
                assign w_d_in   = r_d[g-1];
            end

            always_comb begin
                logic [pbsa_pkg::LANE_W-1:0]   rem;
                logic [pbsa_pkg::LANE_W-1:0]   dq;
                logic [2*pbsa_pkg::LANE_W-1:0] step;
                n_rem[g] = '0;
                n_dq[g]  = '0;
                for (int l = 0; l < pbsa_pkg::LANES; l++) begin
                    rem = w_rem_in[l*pbsa_pkg::LANE_W +: pbsa_pkg::LANE_W];
                    dq  = w_dq_in[l*pbsa_pkg::LANE_W +: pbsa_pkg::LANE_W];
                    for (int s = 0; s < pbsa_pkg::DIV_STEPS; s++) begin
                        step = pbsa_pkg::div_step(rem, dq,
                                   w_d_in[l*pbsa_pkg::LANE_W +: pbsa_pkg::LANE_W]);
                        rem  = step[2*pbsa_pkg::LANE_W-1:pbsa_pkg::LANE_W];
                        dq   = step[pbsa_pkg::LANE_W-1:0];
                    end
                    n_rem[g][l*pbsa_pkg::LANE_W +: pbsa_pkg::LANE_W] = rem;
                    n_dq[g][l*pbsa_pkg::LANE_W +: pbsa_pkg::LANE_W]  = dq;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_rem[g] <= n_rem[g];
                    r_dq[g]  <= n_dq[g];
                    r_d[g]   <= w_d_in;
                end
            end
        end
    endgenerate

    assign o_quotient  = r_dq[pbsa_pkg::DIV_STAGES-1];
    assign o_remainder = r_rem[pbsa_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

[sv/packed_byte_simd_alu.sv]
// Top level of the packed byte SIMD ALU: operand stage, divider pipeline, output stage.
// Depends on pbsa_pkg and pbsa_divider.
`default_nettype none

// Lane-wise ALU over eight signed byte lanes (lane 0 in bits 7:0). One transaction
// is accepted every cycle while s_tready is high, whatever the operation: every code
// runs through the same pipeline of an operand stage, the divider, which resolves two
// quotient bits per stage over four stages, and an output stage. Stalls on
// the output side ripple back only as far as the first empty stage, so bubbles are
// squeezed out and s_tready stays high while any stage can still advance.
// Add, sub and mul wrap to 8 bits; div truncates toward zero and mod takes the
// dividend's sign. A zero divisor gives -1 for div and the dividend for mod and
// sets that lane's bit of zero_divisor_mask; the mask is zero in all other modes.
// Unused operation codes return zero.

module packed_byte_simd_alu (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [135:0] s_tdata,   // mode[3:0], operand_a[67:4], operand_b[131:68], pad
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [71:0]  m_tdata    // lane_result[63:0], zero_divisor_mask[71:64]
);

    localparam int LW = pbsa_pkg::LANE_W;
    localparam int NL = pbsa_pkg::LANES;
    localparam int PS = pbsa_pkg::PIPE_STAGES;
    localparam int DS = pbsa_pkg::DIV_STAGES;

    // Everything an item needs besides the divider's own words
    typedef struct packed {
        pbsa_pkg::t_mode              mode;
        logic [pbsa_pkg::WORD_W-1:0]  res;     // result of the non-dividing ops
        logic [pbsa_pkg::WORD_W-1:0]  a;       // raw dividend, for mod by zero
        logic [NL-1:0]                zmask;
        logic [NL-1:0]                qneg;
        logic [NL-1:0]                rneg;
    } t_side;

    logic [PS-1:0]               r_vld;
    logic [PS-1:0]               w_adv;
    t_side                       r_side [DS+1];
    t_side                       n_side;
    logic [pbsa_pkg::WORD_W-1:0] r_amag, n_amag;
    logic [pbsa_pkg::WORD_W-1:0] r_bmag, n_bmag;
    logic [71:0]                 r_out, n_out;
    logic [pbsa_pkg::WORD_W-1:0] w_quo, w_rem;

    // ---- handshake: a stage advances when it is empty or its successor advances
    always_comb begin
        w_adv[PS-1] = ~r_vld[PS-1] | m_tready;
        for (int k = PS - 2; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    assign s_tready = w_adv[0];
    assign m_tvalid = r_vld[PS-1];
    assign m_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_adv & {r_vld[PS-2:0], s_tvalid}) | (~w_adv & r_vld);
        end
    end

    // ---- operand stage: simple ops, magnitudes and signs for the divider
    always_comb begin
        logic [3:0]    mode_bits;
        logic [LW-1:0] x, y, r;
        logic          is_div;
        mode_bits   = s_tdata[3:0];
        n_side      = '0;
        n_side.mode = pbsa_pkg::t_mode'(mode_bits);
        n_side.a    = s_tdata[67:4];
        n_amag      = '0;
        n_bmag      = '0;
        is_div      = (n_side.mode == pbsa_pkg::MODE_DIV) || (n_side.mode == pbsa_pkg::MODE_MOD);
        for (int l = 0; l < NL; l++) begin
            x = s_tdata[4 + l*LW +: LW];
            y = s_tdata[68 + l*LW +: LW];
            case (n_side.mode)
                pbsa_pkg::MODE_ADD:   r = x + y;
                pbsa_pkg::MODE_SUB:   r = x - y;
                pbsa_pkg::MODE_MUL:   r = LW'(x * y);
                pbsa_pkg::MODE_AND:   r = x & y;
                pbsa_pkg::MODE_OR:    r = x | y;
                pbsa_pkg::MODE_NOT:   r = ~x;
                pbsa_pkg::MODE_XOR:   r = x ^ y;
                pbsa_pkg::MODE_NAND:  r = ~(x & y);
                pbsa_pkg::MODE_NOR:   r = ~(x | y);
                pbsa_pkg::MODE_EQUAL: r = (x == y) ? '1 : '0;
                default:              r = '0;
            endcase
            n_side.res[l*LW +: LW] = r;
            n_side.zmask[l]        = is_div && (y == '0);
            n_side.qneg[l]         = x[LW-1] ^ y[LW-1];
            n_side.rneg[l]         = x[LW-1];
            n_amag[l*LW +: LW]     = x[LW-1] ? LW'(-x) : x;
            n_bmag[l*LW +: LW]     = y[LW-1] ? LW'(-y) : y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_side[0] <= n_side;
            r_amag    <= n_amag;
            r_bmag    <= n_bmag;
        end
    end

    // ---- divider stages; side data travels alongside
    pbsa_divider u_div (
        .i_clk       (i_clk),
        .i_en        (w_adv[DS:1]),
        .i_dividend  (r_amag),
        .i_divisor   (r_bmag),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    genvar g;
    generate
        for (g = 1; g <= DS; g++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (w_adv[g]) begin
                    r_side[g] <= r_side[g-1];
                end
            end
        end
    endgenerate

    // ---- output stage: restore signs, patch zero divisors, select the result
    always_comb begin
        logic [LW-1:0] q, rm, r;
        t_side         sd;
        sd = r_side[DS];
        for (int l = 0; l < NL; l++) begin
            q  = w_quo[l*LW +: LW];
            rm = w_rem[l*LW +: LW];
            case (sd.mode)
                pbsa_pkg::MODE_DIV: begin
                    if (sd.zmask[l]) r = '1;
                    else             r = sd.qneg[l] ? LW'(-q) : q;
                end
                pbsa_pkg::MODE_MOD: begin
                    if (sd.zmask[l]) r = sd.a[l*LW +: LW];
                    else             r = sd.rneg[l] ? LW'(-rm) : rm;
                end
                default: r = sd.res[l*LW +: LW];
            endcase
            n_out[l*LW +: LW] = r;
        end
        n_out[71:64] = sd.zmask;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[PS-1]) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

[sim/packed_byte_simd_alu_checker.sv]
// Scoreboard for packed_byte_simd_alu: watches both stream channels, predicts each lane-wise result
// and compares it in order with what the block returns.
// Depends on pbsa_pkg for the lane geometry and the operation codes.
`timescale 1ns / 100ps

module packed_byte_simd_alu_checker
    import pbsa_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [135:0] i_s_tdata,     // mode[3:0], operand_a[67:4], operand_b[131:68], pad
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [71:0]  i_m_tdata,     // lane_result[63:0], zero_divisor_mask[71:64]
    output int           o_mismatches,
    output int           o_outstanding,
    output int           o_checked
);

    // Same layout as m_tdata: the mask sits above the lanes.
    typedef struct packed {
        logic [LANES-1:0]  zero_div;
        logic [WORD_W-1:0] lanes;
    } t_alu_word;

    t_alu_word results_due[$];

    // Work each lane out in full integer precision, then keep its low byte.
    function automatic t_alu_word simd_alu_result(
        input logic [3:0]        op,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        t_alu_word r;
        int        x;
        int        y;
        int        v;
        int        i;
        r = '0;
        for (i = 0; i < LANES; i++) begin
            x = $signed(a[LANE_W*i +: LANE_W]);
            y = $signed(b[LANE_W*i +: LANE_W]);
            case (op)
                MODE_ADD:   v = x + y;
                MODE_SUB:   v = x - y;
                MODE_MUL:   v = x * y;
                MODE_DIV: begin
                    if (y == 0) begin
                        v = -1;
                        r.zero_div[i] = 1'b1;
                    end else begin
                        v = x / y;
                    end
                end
                MODE_MOD: begin
                    if (y == 0) begin
                        v = x;
                        r.zero_div[i] = 1'b1;
                    end else begin
                        v = x % y;
                    end
                end
                MODE_AND:   v = x & y;
                MODE_OR:    v = x | y;
                MODE_NOT:   v = ~x;
                MODE_XOR:   v = x ^ y;
                MODE_NAND:  v = ~(x & y);
                MODE_NOR:   v = ~(x | y);
                MODE_EQUAL: v = (x == y) ? 255 : 0;
                default:    v = 0;
            endcase
            r.lanes[LANE_W*i +: LANE_W] = v[LANE_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_alu_word want;
        t_alu_word got;
        if (!i_rst_n) begin
            results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                results_due.push_back(simd_alu_result(i_s_tdata[3:0], i_s_tdata[67:4],
                                                      i_s_tdata[131:68]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                o_checked++;
                if (results_due.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected result, expected none, got lanes %h mask %h",
                             $time, got.lanes, got.zero_div);
                end else begin
                    want = results_due.pop_front();
                    if (got.lanes !== want.lanes) begin
                        o_mismatches++;
                        $display("%0t: lane_result mismatch, expected %h, got %h",
                                 $time, want.lanes, got.lanes);
                    end
                    if (got.zero_div !== want.zero_div) begin
                        o_mismatches++;
                        $display("%0t: zero_divisor_mask mismatch, expected %h, got %h",
                                 $time, want.zero_div, got.zero_div);
                    end
                end
            end
        end
        // Updated after the edge, so a reader sampling at the next edge sees a settled count.
        o_outstanding <= results_due.size();
    end

endmodule

[sim/packed_byte_simd_alu_tb.sv]
// Top of the packed_byte_simd_alu testbench: clock, reset, stimulus, output back-pressure and
// the verdict. Depends on pbsa_pkg, packed_byte_simd_alu and packed_byte_simd_alu_checker.
`timescale 1ns / 100ps

module packed_byte_simd_alu_tb;
    import pbsa_pkg::*;

    localparam logic [3:0] FIRST_UNUSED_MODE = MODE_EQUAL + 4'd1;
    localparam int         HOLDOFF_CYCLES    = 120;    // long enough to fill every stage
    localparam int         STALL_LIMIT       = 2000;   // cycles with no transaction at all
    localparam int         LINGER_CYCLES     = 4 * PIPE_STAGES;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;   // mode[3:0], operand_a[67:4], operand_b[131:68], pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;        // lane_result[63:0], zero_divisor_mask[71:64]

    logic         rx_gaps_on = 1'b1;
    int           holdoff_requests = 0;
    int           holdoff_served = 0;
    int           items_sent = 0;
    int           input_stall_cycles = 0;
    int           quiet_cycles = 0;

    int           mismatches;
    int           outstanding;
    int           checked;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    packed_byte_simd_alu dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    packed_byte_simd_alu_checker scoreboard (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // Watchdog: abandon the run once neither channel has moved a transaction for too long.
    // Also tally the cycles in which the block pushed back on its input.
    always @(posedge clk) begin
        if (s_tvalid && !s_tready) begin
            input_stall_cycles++;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stall bursts while enabled, plus a long hold-off whenever one is
    // requested. The hold-off is counted here so the sender keeps offering meanwhile.
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (holdoff_served != holdoff_requests) begin
                holdoff_served++;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one transaction and hold it until the block takes it.
    task automatic send_item(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b);
        s_tdata  <= {4'b0000, b, a, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_input(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has come back. The first edge lets
    // the scoreboard's count catch up with the last transaction taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Favour the lane values where wrapping, sign and division corner cases live.
    function automatic logic [7:0] random_lane();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return 8'h01;
            default: return r[7:0];
        endcase
    endfunction

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        int          i;
        for (i = 0; i < LANES; i++) begin
            w[LANE_W*i +: LANE_W] = random_lane();
        end
        return w;
    endfunction

    task automatic send_random_items(input int count, input bit gaps);
        logic [3:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        logic [31:0] r;
        logic [31:0] pick;
        int          n;
        int          i;
        for (n = 0; n < count; n++) begin
            r    = $urandom;
            pick = $urandom_range(MODE_ADD, MODE_EQUAL);
            op   = (r[31:27] == 5'd0) ? FIRST_UNUSED_MODE + {2'b00, r[1:0]} : pick[3:0];
            a    = random_word();
            b    = random_word();
            // Give equal something to find: copy a random subset of lanes across.
            if (op == MODE_EQUAL && r[4]) begin
                for (i = 0; i < LANES; i++) begin
                    if (r[8+i]) b[LANE_W*i +: LANE_W] = a[LANE_W*i +: LANE_W];
                end
            end
            send_item(op, a, b);
            if (gaps && $urandom_range(0, 7) == 0) begin
                idle_input($urandom_range(1, 19));
            end
        end
    endtask

    initial begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wrap points of add, sub and mul.
        send_item(MODE_ADD, 64'h7F7F_7F7F_7F7F_7F7F, 64'h0101_0101_0101_0101);
        send_item(MODE_ADD, 64'h8080_8080_8080_8080, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_ADD, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_item(MODE_SUB, 64'h8000_FF7F_8080_0180, 64'h0101_7F80_7F01_FF80);
        send_item(MODE_SUB, 64'h7F7F_7F7F_7F7F_7F7F, 64'h8080_8080_8080_8080);
        send_item(MODE_MUL, 64'h807F_FF01_8080_7F00, 64'h807F_FF01_FF7F_7F55);

        // Division: mixed signs, zero divisors and the -128 / -1 overflow in one word.
        send_item(MODE_DIV, 64'h8080_7F81_F907_0500, 64'hFF01_FF07_02FE_0000);
        send_item(MODE_MOD, 64'h8080_7F81_F907_0500, 64'hFF01_FF07_02FE_0000);
        send_item(MODE_DIV, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000);
        send_item(MODE_MOD, 64'h807F_0180_FF7F_0080, 64'h0000_0000_0000_0000);
        send_item(MODE_DIV, 64'h8080_8080_8080_8080, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(MODE_MOD, 64'h8080_8080_8080_8080, 64'hFFFF_FFFF_FFFF_FFFF);

        // Bitwise operations over every bit combination, then equality.
        send_item(MODE_AND,  64'hFF00_F0F0_AAAA_5555, 64'h0F0F_FF00_55AA_FF00);
        send_item(MODE_OR,   64'hFF00_F0F0_AAAA_5555, 64'h0F0F_FF00_55AA_FF00);
        send_item(MODE_NOT,  64'hFF00_F0F0_AAAA_5555, 64'h0F0F_FF00_55AA_FF00);
        send_item(MODE_XOR,  64'hFF00_F0F0_AAAA_5555, 64'h0F0F_FF00_55AA_FF00);
        send_item(MODE_NAND, 64'hFF00_F0F0_AAAA_5555, 64'h0F0F_FF00_55AA_FF00);
        send_item(MODE_NOR,  64'hFF00_F0F0_AAAA_5555, 64'h0F0F_FF00_55AA_FF00);
        send_item(MODE_EQUAL, 64'h8001_7FFF_0055_AA80, 64'h8001_7F00_0155_AA7F);
        send_item(MODE_EQUAL, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000);

        // Unused codes must return all zeros whatever the operands.
        for (k = 0; k < 4; k++) begin
            send_item(FIRST_UNUSED_MODE + 4'(k), 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF);
        end

        // Random traffic with idling on both sides.
        send_random_items(800, 1'b1);

        // Pause the sender until the pipeline has emptied completely.
        wait_drained();

        // Hold the receiver off while offering back to back: fill every stage and make the
        // block stall its input.
        holdoff_requests <= holdoff_requests + 1;
        send_random_items(64, 1'b0);

        send_random_items(800, 1'b1);

        // Last stretch at full rate with no idling on either side.
        rx_gaps_on <= 1'b0;
        send_random_items(240, 1'b0);

        wait_drained();
        repeat (LINGER_CYCLES) @(posedge clk);

        $display("Sent %0d transactions over all sixteen operation codes and checked %0d results;",
                 items_sent, checked);
        $display("the block held off its input for %0d cycles.", input_stall_cycles);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
